>>> sv/mcdt_pkg.sv
// ----------------------------------------------------------------------------
// Mouse cursor drag tracker package
// Shared widths, register indexes, reset values and bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcdt_pkg;

   // Coordinate width of the cursor, the anchor and the edge registers.
   localparam int COORD_BITS  = 11;
   // Two extra bits hold the signed sum of a position and a delta.
   localparam int CALC_BITS   = COORD_BITS + 2;
   localparam int STATUS_BITS = 8;
   localparam int DELTA_BITS  = 8;
   // A negated 8-bit delta needs one more bit.
   localparam int STEP_BITS   = DELTA_BITS + 1;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEFT_EDGE   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RIGHT_EDGE  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP_EDGE    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM_EDGE = 2'd3;

   // Reset values.
   localparam logic [COORD_BITS-1:0] LEFT_EDGE_RESET   = COORD_BITS'(10);
   localparam logic [COORD_BITS-1:0] RIGHT_EDGE_RESET  = COORD_BITS'(1300);
   localparam logic [COORD_BITS-1:0] TOP_EDGE_RESET    = COORD_BITS'(10);
   localparam logic [COORD_BITS-1:0] BOTTOM_EDGE_RESET = COORD_BITS'(700);
   localparam logic [COORD_BITS-1:0] POS_RESET         = COORD_BITS'(300);

   // Button bit positions in the status byte.
   localparam int BTN_LEFT   = 0;
   localparam int BTN_RIGHT  = 1;
   localparam int BTN_MIDDLE = 2;

   // Edge registers handed from the register block to the datapath.
   typedef struct packed {
      logic [COORD_BITS-1:0] left_edge;
      logic [COORD_BITS-1:0] right_edge;
      logic [COORD_BITS-1:0] top_edge;
      logic [COORD_BITS-1:0] bottom_edge;
   } edges_type;

   // One result transaction.
   typedef struct packed {
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic                  left_button;
      logic                  right_button;
      logic                  middle_button;
      logic                  press_event;
      logic                  drag_event;
      logic                  release_event;
      logic [COORD_BITS-1:0] circle_center_x;
      logic [COORD_BITS-1:0] circle_center_y;
      logic [COORD_BITS-1:0] circle_radius;
   } rsp_data_type;

endpackage

`default_nettype wire

>>> sv/mcdt_req_if.sv
// ----------------------------------------------------------------------------
// Mouse packet channel
// Valid/ready channel carrying one three-byte relative mouse packet.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcdt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [mcdt_pkg::STATUS_BITS-1:0]       status_byte;
   logic signed [mcdt_pkg::DELTA_BITS-1:0] delta_x;
   logic signed [mcdt_pkg::DELTA_BITS-1:0] delta_y;

   modport source (output valid, status_byte, delta_x, delta_y, input ready);
   modport sink   (input valid, status_byte, delta_x, delta_y, output ready);
endinterface

`default_nettype wire

>>> sv/mcdt_rsp_if.sv
// ----------------------------------------------------------------------------
// Cursor result channel
// Valid/ready channel carrying the cursor, buttons, events and drag circle.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcdt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mcdt_pkg::COORD_BITS-1:0]   cursor_x;
   logic [mcdt_pkg::COORD_BITS-1:0]   cursor_y;
   logic                              left_button;
   logic                              right_button;
   logic                              middle_button;
   logic                              press_event;
   logic                              drag_event;
   logic                              release_event;
   logic [mcdt_pkg::COORD_BITS-1:0]   circle_center_x;
   logic [mcdt_pkg::COORD_BITS-1:0]   circle_center_y;
   logic [mcdt_pkg::COORD_BITS-1:0]   circle_radius;

   modport source (
      output valid, cursor_x, cursor_y, left_button, right_button, middle_button,
             press_event, drag_event, release_event, circle_center_x,
             circle_center_y, circle_radius,
      input  ready
   );
   modport sink (
      input  valid, cursor_x, cursor_y, left_button, right_button, middle_button,
             press_event, drag_event, release_event, circle_center_x,
             circle_center_y, circle_radius,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/mcdt_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcdt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mcdt_pkg::CSR_IDX_BITS-1:0]  index;
   logic [mcdt_pkg::COORD_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/mcdt_csr_regs.sv
// ----------------------------------------------------------------------------
// Edge configuration registers
// Holds the four clamp edges; a write transaction is taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdt_csr_regs (
   input  wire logic                clock,
   input  wire logic                reset,
   mcdt_csr_if.sink                 csr,
   output mcdt_pkg::edges_type      edges
);

   mcdt_pkg::edges_type edges_ff;
   mcdt_pkg::edges_type edges_in;
   logic                wr_en;

   // Writes never stall.
   assign csr.ready = 1'b1;
   assign wr_en     = csr.valid && csr.ready;

   // Decode the register index.
   always_comb begin
      edges_in = edges_ff;
      if (wr_en) begin
         case (csr.index)
            mcdt_pkg::CSR_LEFT_EDGE:   edges_in.left_edge   = csr.data;
            mcdt_pkg::CSR_RIGHT_EDGE:  edges_in.right_edge  = csr.data;
            mcdt_pkg::CSR_TOP_EDGE:    edges_in.top_edge    = csr.data;
            mcdt_pkg::CSR_BOTTOM_EDGE: edges_in.bottom_edge = csr.data;
            default:                   edges_in             = edges_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff.left_edge   <= mcdt_pkg::LEFT_EDGE_RESET;
         edges_ff.right_edge  <= mcdt_pkg::RIGHT_EDGE_RESET;
         edges_ff.top_edge    <= mcdt_pkg::TOP_EDGE_RESET;
         edges_ff.bottom_edge <= mcdt_pkg::BOTTOM_EDGE_RESET;
      end else begin
         edges_ff <= edges_in;
      end
   end

   assign edges = edges_ff;

endmodule

`default_nettype wire

>>> sv/mcdt_axis_clamp.sv
// ----------------------------------------------------------------------------
// Axis move and clamp
// Moves one coordinate by a signed step when it lies strictly between its
// edges, then clamps it: low edge first, then high edge on that result.
// ----------------------------------------------------------------------------
`default_nettype none

module mcdt_axis_clamp (
   input  wire logic [mcdt_pkg::COORD_BITS-1:0]       pos,
   input  wire logic signed [mcdt_pkg::STEP_BITS-1:0] step,
   input  wire logic [mcdt_pkg::COORD_BITS-1:0]       lo_edge,
   input  wire logic [mcdt_pkg::COORD_BITS-1:0]       hi_edge,
   output logic [mcdt_pkg::COORD_BITS-1:0]            new_pos
);

   localparam int CW = mcdt_pkg::COORD_BITS;
   localparam int SW = mcdt_pkg::CALC_BITS;
   localparam int DW = mcdt_pkg::STEP_BITS;

   logic signed [SW-1:0] pos_s;
   logic signed [SW-1:0] lo_s;
   logic signed [SW-1:0] hi_s;
   logic signed [SW-1:0] step_s;
   logic signed [SW-1:0] moved;
   logic signed [SW-1:0] low_clamped;
   logic signed [SW-1:0] high_clamped;

   // Widen everything to a signed range that holds edge+1, edge-1 and the sum.
   assign pos_s  = signed'({2'b00, pos});
   assign lo_s   = signed'({2'b00, lo_edge});
   assign hi_s   = signed'({2'b00, hi_edge});
   assign step_s = signed'({{(SW-DW){step[DW-1]}}, step});

   // The step only applies while the position is inside both edges.
   assign moved = ((pos_s > lo_s) && (pos_s < hi_s)) ? pos_s + step_s : pos_s;

   // The high-edge clamp is applied last, so it wins a conflict.
   assign low_clamped  = (moved <= lo_s) ? lo_s + SW'(1) : moved;
   assign high_clamped = (low_clamped >= hi_s) ? hi_s - SW'(1) : low_clamped;

   // Edge wrap is modulo the coordinate width.
   assign new_pos = high_clamped[CW-1:0];

endmodule

`default_nettype wire

>>> sv/mouse_cursor_drag_tracker_unit.sv
// ----------------------------------------------------------------------------
// Mouse cursor drag tracker
// Decodes relative mouse packets, moves and clamps a cursor, and reports
// left-button press, drag and release with the drag circle.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Transaction
//   --------+-----+----------------------------------------------------------
//   req     | in  | status_byte, delta_x, delta_y (one mouse packet)
//   rsp     | out | cursor, buttons, events, circle center and radius
//   csr     | in  | index, data (edge register write)
//
// A packet is captured in an input register and its result is formed
// combinationally by the axis clamps and the event logic into the result
// register; one packet is taken every cycle while the result does not stall.
// Cursor and button history advance when a packet moves into the result
// register, and the anchor then latches on a press. A stalled result holds
// while one more packet waits in the input register. Synchronous reset clears
// valids and history and presets cursor and edges; the anchor has no reset.
//
`default_nettype none

module mouse_cursor_drag_tracker_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   mcdt_req_if.sink    req,
   mcdt_rsp_if.source  rsp,
   mcdt_csr_if.sink    csr
);

   localparam int CW = mcdt_pkg::COORD_BITS;
   localparam int DW = mcdt_pkg::DELTA_BITS;
   localparam int TW = mcdt_pkg::STEP_BITS;

   mcdt_pkg::edges_type    edges;

   // Input stage.
   logic                            in_vld_ff;
   logic                            in_vld_in;
   logic [mcdt_pkg::STATUS_BITS-1:0] status_ff;
   logic signed [DW-1:0]            delta_x_ff;
   logic signed [DW-1:0]            delta_y_ff;

   // Tracking state.
   logic [CW-1:0]                   pos_x_ff;
   logic [CW-1:0]                   pos_y_ff;
   logic [CW-1:0]                   anchor_x_ff;
   logic [CW-1:0]                   anchor_y_ff;
   logic                            prev_left_ff;

   // Result stage.
   logic                            rsp_vld_ff;
   logic                            rsp_vld_in;
   mcdt_pkg::rsp_data_type          rsp_data_ff;
   mcdt_pkg::rsp_data_type          rsp_data_in;

   logic                            req_fire;
   logic                            advance;
   logic signed [TW-1:0]            step_x;
   logic signed [TW-1:0]            step_y;
   logic [CW-1:0]                   new_x;
   logic [CW-1:0]                   new_y;
   logic                            left_btn;
   logic                            press;
   logic                            drag;
   logic                            release_evt;

   mcdt_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .edges (edges)
   );

   // Handshake: the input stage moves on whenever the result register frees.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;
   assign req_fire  = req.valid && req.ready;

   assign in_vld_in  = req_fire || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp.ready);

   // Screen y grows downward, so the vertical delta is negated.
   assign step_x = TW'(delta_x_ff);
   assign step_y = -TW'(delta_y_ff);

   mcdt_axis_clamp u_axis_x (
      .pos     (pos_x_ff),
      .step    (step_x),
      .lo_edge (edges.left_edge),
      .hi_edge (edges.right_edge),
      .new_pos (new_x)
   );

   mcdt_axis_clamp u_axis_y (
      .pos     (pos_y_ff),
      .step    (step_y),
      .lo_edge (edges.top_edge),
      .hi_edge (edges.bottom_edge),
      .new_pos (new_y)
   );

   // Left-button edge detection against the previous packet.
   assign left_btn    = status_ff[mcdt_pkg::BTN_LEFT];
   assign press       = !prev_left_ff && left_btn;
   assign drag        = prev_left_ff && left_btn;
   assign release_evt = prev_left_ff && !left_btn;

   // Result assembly; the circle fields are zero outside a drag.
   always_comb begin
      rsp_data_in                 = '0;
      rsp_data_in.cursor_x        = new_x;
      rsp_data_in.cursor_y        = new_y;
      rsp_data_in.left_button     = left_btn;
      rsp_data_in.right_button    = status_ff[mcdt_pkg::BTN_RIGHT];
      rsp_data_in.middle_button   = status_ff[mcdt_pkg::BTN_MIDDLE];
      rsp_data_in.press_event     = press;
      rsp_data_in.drag_event      = drag;
      rsp_data_in.release_event   = release_evt;
      if (drag) begin
         rsp_data_in.circle_center_x = (new_x < anchor_x_ff) ? new_x : anchor_x_ff;
         rsp_data_in.circle_center_y = (new_y < anchor_y_ff) ? new_y : anchor_y_ff;
         rsp_data_in.circle_radius   = (new_x >= anchor_x_ff) ? new_x - anchor_x_ff
                                                              : anchor_x_ff - new_x;
      end
   end

   // Control and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         pos_x_ff     <= mcdt_pkg::POS_RESET;
         pos_y_ff     <= mcdt_pkg::POS_RESET;
         prev_left_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            pos_x_ff     <= new_x;
            pos_y_ff     <= new_y;
            prev_left_ff <= left_btn;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff  <= req.status_byte;
         delta_x_ff <= req.delta_x;
         delta_y_ff <= req.delta_y;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      // A press latches the new cursor as the drag anchor.
      if (advance && press) begin
         anchor_x_ff <= new_x;
         anchor_y_ff <= new_y;
      end
   end

   assign rsp.valid           = rsp_vld_ff;
   assign rsp.cursor_x        = rsp_data_ff.cursor_x;
   assign rsp.cursor_y        = rsp_data_ff.cursor_y;
   assign rsp.left_button     = rsp_data_ff.left_button;
   assign rsp.right_button    = rsp_data_ff.right_button;
   assign rsp.middle_button   = rsp_data_ff.middle_button;
   assign rsp.press_event     = rsp_data_ff.press_event;
   assign rsp.drag_event      = rsp_data_ff.drag_event;
   assign rsp.release_event   = rsp_data_ff.release_event;
   assign rsp.circle_center_x = rsp_data_ff.circle_center_x;
   assign rsp.circle_center_y = rsp_data_ff.circle_center_y;
   assign rsp.circle_radius   = rsp_data_ff.circle_radius;

   // At most one left-button event per result transaction.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> $onehot0({rsp_data_ff.press_event, rsp_data_ff.drag_event,
                               rsp_data_ff.release_event}))
      else $error("more than one left-button event in a result");

   // Press or drag exactly when the left button is down.
   a_event_button: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_data_ff.press_event || rsp_data_ff.drag_event)
                      == rsp_data_ff.left_button))
      else $error("left-button events disagree with the left button");

   // Circle fields stay zero outside a drag.
   a_circle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_data_ff.drag_event) |->
         (rsp_data_ff.circle_center_x == '0 && rsp_data_ff.circle_center_y == '0 &&
          rsp_data_ff.circle_radius == '0))
      else $error("circle fields set outside a drag");

   // A press leaves the anchor equal to the cursor it produced.
   a_anchor_latch: assert property (@(posedge clock) disable iff (reset)
      (advance && press) |=> (anchor_x_ff == pos_x_ff && anchor_y_ff == pos_y_ff))
      else $error("anchor not latched on press");

endmodule

`default_nettype wire
